FILE: src/fcr_pkg.sv
// Shared types and constants for the fraction compare and reduce block.
package fcr_pkg;

  localparam int FIELD_WIDTH = 16;

  localparam logic [1:0] REL_LESS    = 2'd0;
  localparam logic [1:0] REL_EQUAL   = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  typedef enum logic [1:0] {
    SEL_NUM_A = 2'd0,
    SEL_DEN_A = 2'd1,
    SEL_NUM_B = 2'd2,
    SEL_DEN_B = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_left;
    logic     mul_right;
    logic     compare;
    logic     gcd_step;
    logic     div_load;
    logic     div_step;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

FILE: src/fcr_datapath.sv
// Datapath: operand registers, shared multiplier, two subtractive gcd units and a divider.
module fcr_datapath
  import fcr_pkg::*;
#(
  parameter int TERM_WIDTH = 16
) (
  input  logic                   clk,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [FIELD_WIDTH-1:0] num_a,
  input  logic [FIELD_WIDTH-1:0] den_a,
  input  logic [FIELD_WIDTH-1:0] num_b,
  input  logic [FIELD_WIDTH-1:0] den_b,
  output logic                   zero_denominator,
  output logic [1:0]             relation,
  output logic [FIELD_WIDTH-1:0] reduced_num_a,
  output logic [FIELD_WIDTH-1:0] reduced_den_a,
  output logic [FIELD_WIDTH-1:0] reduced_num_b,
  output logic [FIELD_WIDTH-1:0] reduced_den_b
);

  localparam int W  = TERM_WIDTH;
  localparam int PW = 2 * TERM_WIDTH;
  localparam int CW = $clog2(TERM_WIDTH);
  localparam int XW = TERM_WIDTH + FIELD_WIDTH;

  logic [XW-1:0] ext_na, ext_da, ext_nb, ext_db;
  logic [W-1:0]  term_na, term_da, term_nb, term_db;

  logic [W-1:0]  na, da, nb, db;
  logic [W-1:0]  xa, ya, xb, yb;
  logic [PW-1:0] prod_l, prod_r, product;
  logic [W-1:0]  mul_a, mul_b;
  logic [1:0]    rel;
  logic          zero;
  logic          a_done, b_done;

  logic [W-1:0]  rem, quo, dvs;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dividend, divisor;
  logic [W:0]    trial, diff;
  logic          ge;
  logic [W-1:0]  rem_next, quo_next;
  logic          last;

  logic [W-1:0]  res [4];
  logic [XW-1:0] wide_na, wide_da, wide_nb, wide_db;

  assign ext_na  = {{W{1'b0}}, num_a};
  assign ext_da  = {{W{1'b0}}, den_a};
  assign ext_nb  = {{W{1'b0}}, num_b};
  assign ext_db  = {{W{1'b0}}, den_b};
  assign term_na = ext_na[W-1:0];
  assign term_da = ext_da[W-1:0];
  assign term_nb = ext_nb[W-1:0];
  assign term_db = ext_db[W-1:0];

  assign mul_a   = cmd.mul_right ? nb : na;
  assign mul_b   = cmd.mul_right ? da : db;
  assign product = PW'(mul_a) * PW'(mul_b);

  assign a_done = (xa == '0) || (xa == ya);
  assign b_done = (xb == '0) || (xb == yb);

  always_comb begin
    case (cmd.div_sel)
      SEL_NUM_A: begin
        dividend = na;
        divisor  = ya;
      end
      SEL_DEN_A: begin
        dividend = da;
        divisor  = ya;
      end
      SEL_NUM_B: begin
        dividend = nb;
        divisor  = yb;
      end
      SEL_DEN_B: begin
        dividend = db;
        divisor  = yb;
      end
      default: begin
        dividend = na;
        divisor  = ya;
      end
    endcase
  end

  assign trial    = {rem, quo[W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  assign quo_next = {quo[W-2:0], ge};
  assign last     = cnt == CW'(W - 1);

  assign status.zero     = zero;
  assign status.gcd_done = a_done && b_done;
  assign status.div_last = last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na   <= term_na;
      da   <= term_da;
      nb   <= term_nb;
      db   <= term_db;
      xa   <= term_na;
      ya   <= term_da;
      xb   <= term_nb;
      yb   <= term_db;
      zero <= (term_da == '0) || (term_db == '0);
      rel  <= REL_LESS;
      for (int i = 0; i < 4; i++) begin
        res[i] <= '0;
      end
    end else begin
      if (cmd.mul_left) begin
        prod_l <= product;
      end
      if (cmd.mul_right) begin
        prod_r <= product;
      end
      if (cmd.compare) begin
        if (prod_l < prod_r) begin
          rel <= REL_LESS;
        end else if (prod_l == prod_r) begin
          rel <= REL_EQUAL;
        end else begin
          rel <= REL_GREATER;
        end
      end
      if (cmd.gcd_step) begin
        if (!a_done) begin
          if (xa > ya) begin
            xa <= xa - ya;
          end else begin
            ya <= ya - xa;
          end
        end
        if (!b_done) begin
          if (xb > yb) begin
            xb <= xb - yb;
          end else begin
            yb <= yb - xb;
          end
        end
      end
      if (cmd.div_load) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= '0;
      end
      if (cmd.div_step) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (last) begin
          res[cmd.div_sel] <= quo_next;
        end
      end
    end
  end

  assign wide_na = {{FIELD_WIDTH{1'b0}}, res[0]};
  assign wide_da = {{FIELD_WIDTH{1'b0}}, res[1]};
  assign wide_nb = {{FIELD_WIDTH{1'b0}}, res[2]};
  assign wide_db = {{FIELD_WIDTH{1'b0}}, res[3]};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      zero_denominator <= zero;
      relation         <= rel;
      reduced_num_a    <= wide_na[FIELD_WIDTH-1:0];
      reduced_den_a    <= wide_da[FIELD_WIDTH-1:0];
      reduced_num_b    <= wide_nb[FIELD_WIDTH-1:0];
      reduced_den_b    <= wide_db[FIELD_WIDTH-1:0];
    end
  end

endmodule

FILE: src/fcr_controller.sv
// Controller: sequences compare, gcd and division steps and owns the handshakes.
module fcr_controller
  import fcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MUL_L    = 8'b0000_0010,
    S_MUL_R    = 8'b0000_0100,
    S_CMP      = 8'b0000_1000,
    S_GCD      = 8'b0001_0000,
    S_DIV_LOAD = 8'b0010_0000,
    S_DIV_RUN  = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t   state, state_next;
  div_sel_t sel, sel_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.div_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = SEL_NUM_A;
          state_next = S_MUL_L;
        end
      end
      S_MUL_L: begin
        if (status.zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.mul_left = 1'b1;
          state_next   = S_MUL_R;
        end
      end
      S_MUL_R: begin
        cmd.mul_right = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_GCD;
      end
      S_GCD: begin
        if (status.gcd_done) begin
          state_next = S_DIV_LOAD;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          case (sel)
            SEL_NUM_A: sel_next = SEL_DEN_A;
            SEL_DEN_A: sel_next = SEL_NUM_B;
            SEL_NUM_B: sel_next = SEL_DEN_B;
            default:   sel_next = SEL_NUM_A;
          endcase
          state_next = (sel == SEL_DEN_B) ? S_FINISH : S_DIV_LOAD;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= SEL_NUM_A;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/fraction_compare_reduce.sv
// Top level of the fraction compare and reduce block: controller, datapath and checks.
//
//  channel | signals              | payload
//  --------+----------------------+---------------------------------------------------
//  input   | in_valid / in_ready  | num_a, den_a, num_b, den_b
//  output  | out_valid / out_ready| zero_denominator, relation, reduced_num_a/den_a/num_b/den_b
//
// One beat is worked on at a time; a beat runs the two products, the compare, the
// subtraction loop of both gcd units and then the four divisions in turn, while a zero
// denominator goes straight to the finish after the load.
// The division runs one quotient bit per cycle.
// Reset is synchronous and clears the controller and the output valid flag.
// A new beat is taken while a finished result waits in the output register.
module fraction_compare_reduce
  import fcr_pkg::*;
#(
  parameter int TERM_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FIELD_WIDTH-1:0] num_a,
  input  logic [FIELD_WIDTH-1:0] den_a,
  input  logic [FIELD_WIDTH-1:0] num_b,
  input  logic [FIELD_WIDTH-1:0] den_b,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   zero_denominator,
  output logic [1:0]             relation,
  output logic [FIELD_WIDTH-1:0] reduced_num_a,
  output logic [FIELD_WIDTH-1:0] reduced_den_a,
  output logic [FIELD_WIDTH-1:0] reduced_num_b,
  output logic [FIELD_WIDTH-1:0] reduced_den_b
);

  cmd_t    cmd;
  status_t status;

  fcr_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fcr_datapath #(
    .TERM_WIDTH (TERM_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .num_a            (num_a),
    .den_a            (den_a),
    .num_b            (num_b),
    .den_b            (den_b),
    .zero_denominator (zero_denominator),
    .relation         (relation),
    .reduced_num_a    (reduced_num_a),
    .reduced_den_a    (reduced_den_a),
    .reduced_num_b    (reduced_num_b),
    .reduced_den_b    (reduced_den_b)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block took a beat while still busy");

  a_zero_clears_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_denominator) |-> (relation == REL_LESS && reduced_num_a == '0 &&
      reduced_den_a == '0 && reduced_num_b == '0 && reduced_den_b == '0))
    else $error("zero denominator result carries nonzero fields");

  a_reduced_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !zero_denominator) |-> (reduced_den_a != '0 && reduced_den_b != '0 &&
      relation != 2'd3))
    else $error("valid result has a zero reduced denominator or bad relation");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");
`endif

endmodule
